@@ design/htseg_pkg.sv @@
`default_nettype none
package htseg_pkg;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_BANG = 8'h21;

  localparam logic [3:0] OPEN_LEN     = 4'd7;
  localparam logic [3:0] CLOSE_LEN    = 4'd8;
  localparam logic [3:0] HTML_END_LEN = 4'd7;
  localparam logic [3:0] COUNT_MAX    = 4'd8;

  // running matchers for the open segment
  typedef struct packed {
    logic [3:0] count;
    logic       up_open_ok;
    logic       lo_open_ok;
    logic [3:0] up_close_pos;
    logic [3:0] lo_close_pos;
    logic       close_seen;
    logic       html_end_ok;
  } seg_t;

  typedef struct packed {
    logic in_element;
    logic in_comment;
    logic in_script;
    seg_t seg;
  } state_t;

  typedef struct packed {
    logic seg_start;
    logic seg_end;
    logic doc_end;
  } flags_t;

  localparam seg_t SEG_CLEAR = '{
    count:        4'd0,
    up_open_ok:   1'b1,
    lo_open_ok:   1'b1,
    up_close_pos: 4'd0,
    lo_close_pos: 4'd0,
    close_seen:   1'b0,
    html_end_ok:  1'b1
  };

  localparam state_t STATE_RESET = '{
    in_element: 1'b0,
    in_comment: 1'b0,
    in_script:  1'b0,
    seg:        SEG_CLEAR
  };

endpackage
`default_nettype wire

@@ design/htseg_if.sv @@
`default_nettype none
interface htseg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface htseg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       seg_start;
  logic       seg_end;
  logic       doc_end;

  modport source (output valid, output out_byte, output seg_start, output seg_end,
                  output doc_end, input ready);
  modport sink (input valid, input out_byte, input seg_start, input seg_end,
                input doc_end, output ready);
endinterface
`default_nettype wire

@@ design/htseg_step.sv @@
`default_nettype none
module htseg_step (
  input  wire logic [7:0]        data_byte,
  input  wire htseg_pkg::state_t state,
  output htseg_pkg::state_t      state_nxt,
  output htseg_pkg::flags_t      flags
);

  function automatic logic [7:0] open_char(input logic upper, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = htseg_pkg::CH_LT;
      3'd1:    ch = upper ? "S" : "s";
      3'd2:    ch = upper ? "C" : "c";
      3'd3:    ch = upper ? "R" : "r";
      3'd4:    ch = upper ? "I" : "i";
      3'd5:    ch = upper ? "P" : "p";
      3'd6:    ch = upper ? "T" : "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] close_char(input logic upper, input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = htseg_pkg::CH_LT;
      3'd1:    ch = "/";
      3'd2:    ch = upper ? "S" : "s";
      3'd3:    ch = upper ? "C" : "c";
      3'd4:    ch = upper ? "R" : "r";
      3'd5:    ch = upper ? "I" : "i";
      3'd6:    ch = upper ? "P" : "p";
      3'd7:    ch = upper ? "T" : "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] html_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = htseg_pkg::CH_LT;
      3'd1:    ch = "/";
      3'd2:    ch = "H";
      3'd3:    ch = "T";
      3'd4:    ch = "M";
      3'd5:    ch = "L";
      3'd6:    ch = htseg_pkg::CH_GT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // substring search; '<' occurs only at the head of the pattern
  function automatic logic [3:0] search_next(input logic [3:0] pos, input logic [7:0] c,
                                             input logic upper);
    logic [3:0] nxt;
    if (pos >= htseg_pkg::CLOSE_LEN) begin
      nxt = htseg_pkg::CLOSE_LEN;
    end else if (c == close_char(upper, pos[2:0])) begin
      nxt = pos + 4'd1;
    end else begin
      nxt = (c == htseg_pkg::CH_LT) ? 4'd1 : 4'd0;
    end
    return nxt;
  endfunction

  function automatic htseg_pkg::seg_t append(input htseg_pkg::seg_t s, input logic [7:0] c);
    htseg_pkg::seg_t r;
    r = s;
    if (s.count < htseg_pkg::OPEN_LEN) begin
      r.up_open_ok = s.up_open_ok && (c == open_char(1'b1, s.count[2:0]));
      r.lo_open_ok = s.lo_open_ok && (c == open_char(1'b0, s.count[2:0]));
    end
    if (s.count < htseg_pkg::HTML_END_LEN) begin
      r.html_end_ok = s.html_end_ok && (c == html_char(s.count[2:0]));
    end
    r.up_close_pos = search_next(s.up_close_pos, c, 1'b1);
    r.lo_close_pos = search_next(s.lo_close_pos, c, 1'b0);
    if (r.up_close_pos >= htseg_pkg::CLOSE_LEN || r.lo_close_pos >= htseg_pkg::CLOSE_LEN) begin
      r.close_seen = 1'b1;
    end
    if (s.count < htseg_pkg::COUNT_MAX) begin
      r.count = s.count + 4'd1;
    end
    return r;
  endfunction

  htseg_pkg::seg_t base_seg;
  htseg_pkg::seg_t grown_seg;
  logic            is_lt_open;
  logic            is_gt;
  logic            open_hit;

  always_comb begin
    is_lt_open = (data_byte == htseg_pkg::CH_LT) && !state.in_script &&
                 !(state.in_element && state.in_comment);
    is_gt      = (data_byte == htseg_pkg::CH_GT);
    open_hit   = (state.seg.count >= htseg_pkg::OPEN_LEN) &&
                 (state.seg.up_open_ok || state.seg.lo_open_ok);
    base_seg   = (is_lt_open || !state.in_element) ? htseg_pkg::SEG_CLEAR : state.seg;
    grown_seg  = append(base_seg, data_byte);

    state_nxt  = state;
    flags      = '0;

    if (is_lt_open) begin
      flags.seg_start      = 1'b1;
      state_nxt.in_element = 1'b1;
      state_nxt.seg        = grown_seg;
    end else if (is_gt) begin
      // close test wins over open in the same segment
      if (state.seg.close_seen) begin
        state_nxt.in_script = 1'b0;
      end else if (open_hit) begin
        state_nxt.in_script = 1'b1;
      end
      flags.seg_start = !state.in_element;
      if (!state_nxt.in_script) begin
        flags.seg_end        = 1'b1;
        flags.doc_end        = (grown_seg.count == htseg_pkg::HTML_END_LEN) &&
                               grown_seg.html_end_ok;
        state_nxt.in_element = 1'b0;
        state_nxt.seg        = htseg_pkg::SEG_CLEAR;
      end else begin
        state_nxt.in_element = 1'b1;
        state_nxt.seg        = grown_seg;
      end
      state_nxt.in_comment = 1'b0;
    end else begin
      if (data_byte == htseg_pkg::CH_BANG && state.seg.count == 4'd1 && !state.in_script) begin
        state_nxt.in_comment = 1'b1;
      end
      flags.seg_start      = !state.in_element;
      state_nxt.in_element = 1'b1;
      state_nxt.seg        = grown_seg;
    end
  end

endmodule
`default_nettype wire

@@ design/html_tag_text_segmenter_unit.sv @@
// Latency: a byte accepted at one edge shows its result from the next cycle.
// Throughput: one byte per cycle; the segment flags and matchers update in a
// single pass of logic between the state registers and the result register.
// The result register takes a new byte whenever it is empty or being drained.
// Reset (synchronous, rst_n low) clears the segment state and the result valid.
`default_nettype none
module html_tag_text_segmenter_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  htseg_in_if.sink    in_ch,
  htseg_out_if.source out_ch
);

  htseg_pkg::state_t state_r;
  htseg_pkg::state_t state_nxt;
  htseg_pkg::flags_t flags_nxt;
  htseg_pkg::flags_t flags_r;
  logic [7:0]        out_byte_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              in_ready;
  logic              in_fire;
  logic              out_fire;

  htseg_step u_step (
    .data_byte (in_ch.data_byte),
    .state     (state_r),
    .state_nxt (state_nxt),
    .flags     (flags_nxt)
  );

  assign in_ready      = !out_valid_r || out_ch.ready;
  assign in_fire       = in_ch.valid && in_ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.seg_start = flags_r.seg_start;
  assign out_ch.seg_end   = flags_r.seg_end;
  assign out_ch.doc_end   = flags_r.doc_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htseg_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload: load on every input transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r <= in_ch.data_byte;
      flags_r    <= flags_nxt;
    end
  end

  a_doc_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flags_r.doc_end |-> flags_r.seg_end)
    else $error("doc_end without seg_end");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !in_fire |=> !out_valid_r)
    else $error("result register not emptied after transfer");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(state_r))
    else $error("segment state changed without an input transfer");

  a_closed_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.in_element |-> state_r.seg == htseg_pkg::SEG_CLEAR)
    else $error("matchers not cleared outside a segment");

endmodule
`default_nettype wire
